// ===== rtl/terminal_line_editor_defines.svh =====
// ----------------------------------------------------------------------------
// terminal line editor assertion macros
// concurrent checks clocked on aclk, off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef TERMINAL_LINE_EDITOR_DEFINES_SVH
`define TERMINAL_LINE_EDITOR_DEFINES_SVH

`ifndef SYNTHESIS
`define TLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define TLE_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);
`else
`define TLE_ASSERT(lbl, prop, msg)
`define TLE_NEVER(lbl, expr, msg)
`endif

`endif

// ===== rtl/tle_pkg.sv =====
// ----------------------------------------------------------------------------
// tle_pkg
// shared types and codes of the terminal line editor
// ----------------------------------------------------------------------------
package tle_pkg;

    // request kinds on the input channel
    localparam logic [1:0] OP_BYTE       = 2'd0;
    localparam logic [1:0] OP_CONNECT    = 2'd1;
    localparam logic [1:0] OP_DISCONNECT = 2'd2;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] PRINT_LO   = 8'd32;
    localparam logic [7:0] PRINT_HI   = 8'd126;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ECHO,
        ST_CR,
        ST_LF,
        ST_RD,
        ST_DATA,
        ST_GT,
        ST_SP,
        ST_BS1,
        ST_BS_SP,
        ST_BS2
    } state_t;

    typedef enum logic [2:0] {
        SEL_RX,
        SEL_CR,
        SEL_LF,
        SEL_BS,
        SEL_SP,
        SEL_GT,
        SEL_STORE
    } byte_sel_t;

    typedef struct packed {
        logic      accept;
        logic      cnt_clear;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      ptr_clear;
        logic      ptr_inc;
        logic      store_wr;
        logic      out_load;
        byte_sel_t out_sel;
        logic      out_dest;
        logic      out_line_end;
        logic      out_last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       is_cr;
        logic       is_bs;
        logic       is_print;
        logic       count_zero;
        logic       has_room;
        logic       rd_last;
        logic       out_ready;
    } status_t;

endpackage

// ===== rtl/tle_ram.sv =====
// ----------------------------------------------------------------------------
// tle_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module tle_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 31,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tle_datapath.sv =====
// ----------------------------------------------------------------------------
// tle_datapath
// line store, length counter, read pointer and output register
// ----------------------------------------------------------------------------
module tle_datapath #(
    parameter int LINE_BYTES = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  tle_pkg::cmd_t    cmd,
    output tle_pkg::status_t status,
    input  logic [7:0]       s_tdata,   // rx_byte
    input  logic [1:0]       s_tuser,   // op
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // out_byte
    output logic [1:0]       m_tuser,   // dest, line_end
    output logic             m_tlast
);

    localparam int DEPTH = LINE_BYTES - 1;
    localparam int CW    = $clog2(LINE_BYTES);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [7:0]    rx_reg;
    logic [7:0]    store_rd;
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_dest_reg;
    logic          out_line_end_reg;
    logic          out_last_reg;
    logic [7:0]    sel_byte;

    tle_ram #(
        .DATA_W (8),
        .DEPTH  (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.store_wr),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_addr (ptr_reg),
        .rd_data (store_rd)
    );

    always_comb begin
        count_next = count_reg;
        if (cmd.cnt_clear) begin
            count_next = '0;
        end else if (cmd.cnt_inc) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.cnt_dec) begin
            count_next = count_reg - CW'(1);
        end
        ptr_next = ptr_reg;
        if (cmd.ptr_clear) begin
            ptr_next = '0;
        end else if (cmd.ptr_inc) begin
            ptr_next = ptr_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        unique case (cmd.out_sel)
            tle_pkg::SEL_RX:    sel_byte = rx_reg;
            tle_pkg::SEL_CR:    sel_byte = tle_pkg::CHAR_CR;
            tle_pkg::SEL_LF:    sel_byte = tle_pkg::CHAR_LF;
            tle_pkg::SEL_BS:    sel_byte = tle_pkg::CHAR_BS;
            tle_pkg::SEL_SP:    sel_byte = tle_pkg::CHAR_SPACE;
            tle_pkg::SEL_GT:    sel_byte = tle_pkg::CHAR_GT;
            tle_pkg::SEL_STORE: sel_byte = store_rd;
            default:            sel_byte = tle_pkg::CHAR_SPACE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rx_reg <= s_tdata;
        end
        if (cmd.out_load) begin
            out_byte_reg     <= sel_byte;
            out_dest_reg     <= cmd.out_dest;
            out_line_end_reg <= cmd.out_line_end;
            out_last_reg     <= cmd.out_last;
        end
    end

    always_comb begin
        status.op         = s_tuser;
        status.is_cr      = (s_tdata == tle_pkg::CHAR_CR);
        status.is_bs      = (s_tdata == tle_pkg::CHAR_BS) || (s_tdata == tle_pkg::CHAR_DEL);
        status.is_print   = (s_tdata >= tle_pkg::PRINT_LO) && (s_tdata <= tle_pkg::PRINT_HI);
        status.count_zero = (count_reg == '0);
        status.has_room   = (count_reg < DEPTH_C);
        status.rd_last    = ((CW'(ptr_reg) + CW'(1)) == count_reg);
        status.out_ready  = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_line_end_reg, out_dest_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/tle_ctrl.sv =====
// ----------------------------------------------------------------------------
// tle_ctrl
// sequencer that decodes a request and steps through its output bytes
// ----------------------------------------------------------------------------
module tle_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  tle_pkg::status_t status,
    output tle_pkg::cmd_t    cmd
);

    tle_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tle_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            tle_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    unique case (status.op)
                        tle_pkg::OP_CONNECT: begin
                            cmd.cnt_clear = 1'b1;
                            state_next    = tle_pkg::ST_GT;
                        end
                        tle_pkg::OP_DISCONNECT: begin
                            cmd.cnt_clear = 1'b1;
                        end
                        tle_pkg::OP_BYTE: begin
                            priority if (status.is_cr) begin
                                cmd.ptr_clear = 1'b1;
                                state_next    = tle_pkg::ST_CR;
                            end else if (status.is_bs && !status.count_zero) begin
                                cmd.cnt_dec = 1'b1;
                                state_next  = tle_pkg::ST_BS1;
                            end else if (status.is_print && status.has_room) begin
                                cmd.store_wr = 1'b1;
                                cmd.cnt_inc  = 1'b1;
                                state_next   = tle_pkg::ST_ECHO;
                            end else begin
                                // line feed, backspace on an empty line, full line, other unprintable bytes
                                state_next = tle_pkg::ST_IDLE;
                            end
                        end
                        default: begin
                            state_next = tle_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            tle_pkg::ST_ECHO: begin
                if (status.out_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = tle_pkg::SEL_RX;
                    cmd.out_last = 1'b1;
                    state_next   = tle_pkg::ST_IDLE;
                end
            end
            tle_pkg::ST_CR: begin
                if (status.out_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = tle_pkg::SEL_CR;
                    state_next   = tle_pkg::ST_LF;
                end
            end
            tle_pkg::ST_LF: begin
                if (status.out_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = tle_pkg::SEL_LF;
                    state_next   = status.count_zero ? tle_pkg::ST_GT : tle_pkg::ST_RD;
                end
            end
            tle_pkg::ST_RD: begin
                // store read data arrives in the cycle after the pointer settles
                state_next = tle_pkg::ST_DATA;
            end
            tle_pkg::ST_DATA: begin
                if (status.out_ready) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_sel      = tle_pkg::SEL_STORE;
                    cmd.out_dest     = 1'b1;
                    cmd.out_line_end = status.rd_last;
                    if (status.rd_last) begin
                        cmd.cnt_clear = 1'b1;
                        state_next    = tle_pkg::ST_GT;
                    end else begin
                        cmd.ptr_inc = 1'b1;
                        state_next  = tle_pkg::ST_RD;
                    end
                end
            end
            tle_pkg::ST_GT: begin
                if (status.out_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = tle_pkg::SEL_GT;
                    state_next   = tle_pkg::ST_SP;
                end
            end
            tle_pkg::ST_SP: begin
                if (status.out_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = tle_pkg::SEL_SP;
                    cmd.out_last = 1'b1;
                    state_next   = tle_pkg::ST_IDLE;
                end
            end
            tle_pkg::ST_BS1: begin
                if (status.out_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = tle_pkg::SEL_BS;
                    state_next   = tle_pkg::ST_BS_SP;
                end
            end
            tle_pkg::ST_BS_SP: begin
                if (status.out_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = tle_pkg::SEL_SP;
                    state_next   = tle_pkg::ST_BS2;
                end
            end
            tle_pkg::ST_BS2: begin
                if (status.out_ready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = tle_pkg::SEL_BS;
                    cmd.out_last = 1'b1;
                    state_next   = tle_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tle_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/terminal_line_editor.sv =====
// ----------------------------------------------------------------------------
// terminal_line_editor
// serial console line editor with echo and command line output
// ----------------------------------------------------------------------------
// Takes terminal bytes and connect or disconnect events on the s_ stream and
// emits echo bytes (tuser dest 0) and completed command lines (dest 1, with
// line_end on the final byte) on the m_ stream; tlast marks the final result
// of each request that yields any. A request is taken whenever the sequencer
// is idle, even while its last result still sits in the output register; the
// sequencer then loads the echo, line or prompt bytes one by one, and takes no
// new request until it has loaded them all. A carriage return sends every
// stored byte through the line store's registered read port. There is no
// clearing pass after reset. An output stall holds the sequencer in its state.
// ----------------------------------------------------------------------------
`include "terminal_line_editor_defines.svh"

module terminal_line_editor #(
    parameter int LINE_BYTES = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic [1:0] s_tuser,   // [1:0] op
    input  logic       s_tlast,   // packet_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] dest, [1] line_end
    output logic       m_tlast    // last
);

    tle_pkg::cmd_t    cmd;
    tle_pkg::status_t status;
    logic             pkt_end_unused;

    // packet boundaries carry no meaning for the editor
    assign pkt_end_unused = s_tlast;

    tle_datapath #(
        .LINE_BYTES (LINE_BYTES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    tle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    `TLE_ASSERT(a_load_when_free, cmd.out_load |-> status.out_ready, "result overwritten")
    `TLE_ASSERT(a_write_has_room, cmd.store_wr |-> status.has_room, "line store overrun")
    `TLE_ASSERT(a_count_one_op, $onehot0({cmd.cnt_clear, cmd.cnt_inc, cmd.cnt_dec}), "count ops")
    `TLE_NEVER(a_line_end_cmd, m_tvalid && m_tuser[1] && !m_tuser[0], "line end on echo")

endmodule

// ===== test/terminal_line_editor_checker.sv =====
// ----------------------------------------------------------------------------
// terminal_line_editor_checker
// watches both streams of the line editor, predicts the echo and command
// bytes of every request and compares each result with the oldest one due
// ----------------------------------------------------------------------------
module terminal_line_editor_checker #(
    parameter int LINE_BYTES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] op
    input  logic        s_tlast,   // packet_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] out_byte
    input  logic [1:0]  m_tuser,   // [0] dest, [1] line_end
    input  logic        m_tlast,   // last
    output int unsigned mismatches,
    output int unsigned due_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = LINE_BYTES - 1;

    typedef struct packed {
        logic       dest;
        logic [7:0] data;
        logic       line_end;
        logic       last;
    } console_out_t;

    console_out_t out_bytes_due[$];
    logic [7:0]   line_buf[STORE_DEPTH];
    int           line_len = 0;
    int unsigned  results_seen = 0;

    initial begin
        mismatches = 0;
        due_count  = 0;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t ns, result %0d: %s", $time, results_seen, msg);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        end
    endtask

    function automatic void push_out(input logic dest, input logic [7:0] data,
                                     input logic line_end, input logic last);
        console_out_t r;
        r.dest     = dest;
        r.data     = data;
        r.line_end = line_end;
        r.last     = last;
        out_bytes_due.push_back(r);
    endfunction

    // applies one request to the line and queues the bytes it must produce
    function automatic void edit_line(input logic [1:0] op, input logic [7:0] ch);
        case (op)
            tle_pkg::OP_CONNECT: begin
                line_len = 0;
                push_out(1'b0, tle_pkg::CHAR_GT, 1'b0, 1'b0);
                push_out(1'b0, tle_pkg::CHAR_SPACE, 1'b0, 1'b1);
            end
            tle_pkg::OP_DISCONNECT: begin
                line_len = 0;
            end
            tle_pkg::OP_BYTE: begin
                if (ch == tle_pkg::CHAR_CR) begin
                    push_out(1'b0, tle_pkg::CHAR_CR, 1'b0, 1'b0);
                    push_out(1'b0, tle_pkg::CHAR_LF, 1'b0, 1'b0);
                    for (int i = 0; i < line_len; i++) begin
                        push_out(1'b1, line_buf[i], i == line_len - 1, 1'b0);
                    end
                    line_len = 0;
                    push_out(1'b0, tle_pkg::CHAR_GT, 1'b0, 1'b0);
                    push_out(1'b0, tle_pkg::CHAR_SPACE, 1'b0, 1'b1);
                end else if (ch == tle_pkg::CHAR_LF) begin
                    // line feed is dropped
                end else if (ch == tle_pkg::CHAR_BS || ch == tle_pkg::CHAR_DEL) begin
                    if (line_len > 0) begin
                        line_len--;
                        push_out(1'b0, tle_pkg::CHAR_BS, 1'b0, 1'b0);
                        push_out(1'b0, tle_pkg::CHAR_SPACE, 1'b0, 1'b0);
                        push_out(1'b0, tle_pkg::CHAR_BS, 1'b0, 1'b1);
                    end
                end else if (ch >= tle_pkg::PRINT_LO && ch <= tle_pkg::PRINT_HI) begin
                    if (line_len < STORE_DEPTH) begin
                        line_buf[line_len] = ch;
                        line_len++;
                        push_out(1'b0, ch, 1'b0, 1'b1);
                    end
                end
            end
            default: begin
                // unused op code leaves everything as it is
            end
        endcase
    endfunction

    always @(posedge aclk) begin : monitor
        console_out_t want;
        if (!aresetn) begin
            line_len = 0;
            out_bytes_due.delete();
        end else begin
            // new expectations go to the back, so the order stays intact
            if (s_tvalid && s_tready) begin
                edit_line(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (out_bytes_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result data 0x%0h dest %0d",
                                              m_tdata, m_tuser[0]));
                end else begin
                    want = out_bytes_due.pop_front();
                    check_field("dest", 32'(m_tuser[0]), 32'(want.dest));
                    check_field("out_byte", 32'(m_tdata), 32'(want.data));
                    check_field("line_end", 32'(m_tuser[1]), 32'(want.line_end));
                    check_field("last", 32'(m_tlast), 32'(want.last));
                end
            end
        end
        due_count <= out_bytes_due.size();
    end

endmodule

// ===== test/terminal_line_editor_tb.sv =====
// ----------------------------------------------------------------------------
// terminal_line_editor_tb
// drives terminal bytes and connect events into the line editor with random
// gaps and output stalls; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module terminal_line_editor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         LINE_BYTES     = 32;
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         REQUEST_TARGET = 330;
    localparam int         QUIET_TAIL     = 50;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         DRAIN_CYCLES   = 120;
    localparam int         WATCHDOG_LIMIT = 3000;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic [1:0] s_tuser  = tle_pkg::OP_BYTE;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    int unsigned mismatches;
    int unsigned due_count;
    int          requests_sent = 0;
    bit          idle_on       = 1'b0;
    bit          hold_req      = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    terminal_line_editor #(
        .LINE_BYTES(LINE_BYTES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    terminal_line_editor_checker #(
        .LINE_BYTES(LINE_BYTES)
    ) line_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .mismatches(mismatches),
        .due_count (due_count)
    );

    // offers one request from a falling edge and returns at the falling edge
    // after it was taken, leaving tvalid high
    task automatic send_request(input logic [1:0] op, input logic [7:0] ch,
                                input logic packet_end);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = ch;
        s_tlast  = packet_end;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        requests_sent++;
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_request(tle_pkg::OP_BYTE, ch, 1'($urandom_range(0, 1)));
    endtask

    // a typed line with some edits and stray line feeds, closed by enter
    task automatic type_line();
        int len;
        if ($urandom_range(0, 9) == 0) len = $urandom_range(28, 36);
        else len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) begin
            if (i > 0 && $urandom_range(0, 7) == 0) begin
                send_char($urandom_range(0, 1) ? tle_pkg::CHAR_BS : tle_pkg::CHAR_DEL);
            end else if ($urandom_range(0, 15) == 0) begin
                send_char(tle_pkg::CHAR_LF);
            end else begin
                send_char(8'($urandom_range(tle_pkg::PRINT_LO, tle_pkg::PRINT_HI)));
            end
        end
        send_char(tle_pkg::CHAR_CR);
    endtask

    task automatic random_sequence();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
            type_line();
        end else if (pick < 16) begin
            send_request(tle_pkg::OP_CONNECT, 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
        end else if (pick < 17) begin
            send_request(tle_pkg::OP_DISCONNECT, 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
        end else begin
            repeat ($urandom_range(1, 4)) begin
                send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
            end
        end
    endtask

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("terminal_line_editor regression: fail");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: edges of the printable range, edits, dropped bytes
        send_request(tle_pkg::OP_CONNECT, 8'h00, 1'b0);
        send_request(tle_pkg::OP_BYTE, tle_pkg::CHAR_CR, 1'b1);
        send_request(tle_pkg::OP_BYTE, tle_pkg::CHAR_BS, 1'b0);
        send_request(tle_pkg::OP_BYTE, tle_pkg::CHAR_DEL, 1'b1);
        send_request(tle_pkg::OP_BYTE, tle_pkg::PRINT_LO, 1'b0);
        send_request(tle_pkg::OP_BYTE, tle_pkg::PRINT_HI, 1'b1);
        send_request(tle_pkg::OP_BYTE, 8'd31, 1'b0);
        send_request(tle_pkg::OP_BYTE, 8'h80, 1'b1);
        send_request(tle_pkg::OP_BYTE, 8'hFF, 1'b0);
        send_request(tle_pkg::OP_BYTE, 8'h00, 1'b1);
        send_request(tle_pkg::OP_BYTE, tle_pkg::CHAR_LF, 1'b0);
        send_request(tle_pkg::OP_BYTE, "x", 1'b0);
        send_request(tle_pkg::OP_BYTE, tle_pkg::CHAR_BS, 1'b1);
        send_request(tle_pkg::OP_BYTE, tle_pkg::CHAR_DEL, 1'b0);
        send_request(OP_UNUSED, "z", 1'b1);
        send_request(tle_pkg::OP_BYTE, "q", 1'b1);
        send_request(tle_pkg::OP_BYTE, tle_pkg::CHAR_CR, 1'b0);
        send_request(tle_pkg::OP_BYTE, "k", 1'b0);
        send_request(tle_pkg::OP_DISCONNECT, 8'hA5, 1'b1);
        send_request(tle_pkg::OP_BYTE, tle_pkg::CHAR_CR, 1'b0);
        send_request(OP_UNUSED, 8'hFF, 1'b0);
        send_request(tle_pkg::OP_BYTE, "m", 1'b1);
        send_request(tle_pkg::OP_CONNECT, 8'h5A, 1'b0);
        send_request(tle_pkg::OP_BYTE, tle_pkg::CHAR_CR, 1'b1);

        // long output hold-off while a line is typed, then drain fully
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) begin
            send_char(8'($urandom_range(tle_pkg::PRINT_LO, tle_pkg::PRINT_HI)));
        end
        send_char(tle_pkg::CHAR_CR);
        s_tvalid = 1'b0;
        wait (due_count == 0);
        @(negedge aclk);

        idle_on = 1'b1;
        while (requests_sent < REQUEST_TARGET - QUIET_TAIL) random_sequence();
        idle_on = 1'b0;
        while (requests_sent < REQUEST_TARGET) random_sequence();
        s_tvalid = 1'b0;

        wait (due_count == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("terminal_line_editor regression: pass");
        end else begin
            $display("terminal_line_editor regression: fail");
        end
        $finish;
    end

endmodule
